// ===== src/rhsp_pkg.sv =====
// shared types and constants for the rtp header stream parser
`default_nettype none

package rhsp_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_CSRC    = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    // error codes carried in data_word
    localparam logic [31:0] ERR_VERSION = 32'd0;
    localparam logic [31:0] ERR_SHORT   = 32'd1;

    // fixed header length and position limits
    localparam logic [6:0] HDR_LEN     = 7'd12;
    localparam logic [6:0] HDR_LAST    = 7'd11;
    localparam logic [6:0] MAX_POS     = 7'd72;
    localparam logic [1:0] MAX_VERSION = 2'd2;

    // header octet positions
    localparam logic [6:0] POS_FLAGS1 = 7'd0;
    localparam logic [6:0] POS_FLAGS2 = 7'd1;
    localparam logic [6:0] POS_TIME   = 7'd4;
    localparam logic [6:0] POS_SSRC   = 7'd8;

    // one result of the parser
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  version;
        logic        padding_flag;
        logic        ext_flag;
        logic [3:0]  src_count;
        logic        marker;
        logic [6:0]  pt_code;
        logic [15:0] seq_num;
        logic [31:0] timestamp;
        logic [31:0] ssrc;
        logic [31:0] data_word;
        logic        out_last;
    } t_result;

endpackage

`default_nettype wire

// ===== src/rhsp_if.sv =====
// request channels of the rtp header stream parser: packet octets in, results out
`default_nettype none

interface rhsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       in_last;

    modport source (output valid, output byte_value, output in_last, input ready);
    modport sink   (input valid, input byte_value, input in_last, output ready);
endinterface

interface rhsp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  version;
    logic        padding_flag;
    logic        ext_flag;
    logic [3:0]  src_count;
    logic        marker;
    logic [6:0]  pt_code;
    logic [15:0] seq_num;
    logic [31:0] timestamp;
    logic [31:0] ssrc;
    logic [31:0] data_word;
    logic        out_last;

    modport source (
        output valid, output kind, output version, output padding_flag,
        output ext_flag, output src_count, output marker, output pt_code,
        output seq_num, output timestamp, output ssrc, output data_word,
        output out_last, input ready
    );
    modport sink (
        input valid, input kind, input version, input padding_flag,
        input ext_flag, input src_count, input marker, input pt_code,
        input seq_num, input timestamp, input ssrc, input data_word,
        input out_last, output ready
    );
endinterface

`default_nettype wire

// ===== src/rtp_header_stream_parser_core.sv =====
// rtp header stream parser: each accepted octet goes to the input register, and its result, if any,
// to the result register; throughput one octet per cycle while results are taken, set by
// the combinational parse step between the input register and the result register
// an octet whose result cannot yet be stored waits in the input register
// synchronous active-low reset returns to the start of a packet with all
// header shadows cleared and both registers empty
`default_nettype none

module rtp_header_stream_parser_core (
    input  wire            i_clk,
    input  wire            i_rst_n,
    rhsp_byte_if.sink      i_byte,
    rhsp_result_if.source  o_result
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // parser state
    logic [6:0]  r_byte_position, n_byte_position;
    logic [15:0] r_header_flags,  n_header_flags;
    logic [15:0] r_seq_shadow,    n_seq_shadow;
    logic [31:0] r_time_shadow,   n_time_shadow;
    logic [31:0] r_ssrc_shadow,   n_ssrc_shadow;
    logic [31:0] r_word_assembly, n_word_assembly;
    logic [3:0]  r_csrc_left,     n_csrc_left;
    logic        r_discarding,    n_discarding;

    // result register
    logic                 r_out_valid;
    rhsp_pkg::t_result    r_out;
    rhsp_pkg::t_result    n_res;
    logic                 n_emit;

    logic        s_out_free;
    logic        s_adv;
    logic [6:0]  s_pos_inc;
    logic [31:0] s_word;
    logic [3:0]  s_left_dec;

    // handshake
    assign s_out_free   = !r_out_valid || o_result.ready;
    assign s_adv        = r_in_valid && s_out_free;
    assign i_byte.ready = !r_in_valid || s_adv;

    assign s_pos_inc  = r_byte_position + 7'd1;
    assign s_word     = {r_word_assembly[23:0], r_in_byte};
    assign s_left_dec = r_csrc_left - 4'd1;

    // parse step for the octet in the input register
    always_comb begin
        n_byte_position = r_byte_position;
        n_header_flags  = r_header_flags;
        n_seq_shadow    = r_seq_shadow;
        n_time_shadow   = r_time_shadow;
        n_ssrc_shadow   = r_ssrc_shadow;
        n_word_assembly = r_word_assembly;
        n_csrc_left     = r_csrc_left;
        n_discarding    = r_discarding;
        n_emit          = 1'b0;
        n_res           = '0;
        n_res.out_last  = r_in_last;

        if (r_discarding) begin
            // drop octets up to packet end
            if (r_in_last) begin
                n_byte_position = '0;
                n_word_assembly = '0;
                n_csrc_left     = '0;
                n_discarding    = 1'b0;
            end
        end else if (r_byte_position < rhsp_pkg::HDR_LEN) begin
            // fixed header capture
            if (r_byte_position == rhsp_pkg::POS_FLAGS1) begin
                n_header_flags = {r_in_byte, 8'd0};
            end else if (r_byte_position == rhsp_pkg::POS_FLAGS2) begin
                n_header_flags = {r_header_flags[15:8], r_in_byte};
            end else if (r_byte_position < rhsp_pkg::POS_TIME) begin
                n_seq_shadow = {r_seq_shadow[7:0], r_in_byte};
            end else if (r_byte_position < rhsp_pkg::POS_SSRC) begin
                n_time_shadow = {r_time_shadow[23:0], r_in_byte};
            end else begin
                n_ssrc_shadow = {r_ssrc_shadow[23:0], r_in_byte};
            end
            n_byte_position = s_pos_inc;

            if (r_byte_position == rhsp_pkg::POS_FLAGS1
                    && r_in_byte[7:6] > rhsp_pkg::MAX_VERSION) begin
                // unsupported version
                n_emit             = 1'b1;
                n_res.kind         = rhsp_pkg::KIND_ERROR;
                n_res.data_word    = rhsp_pkg::ERR_VERSION;
                n_res.out_last     = 1'b1;
                n_byte_position    = '0;
                n_word_assembly    = '0;
                n_csrc_left        = '0;
                n_discarding       = !r_in_last;
            end else if (r_byte_position != rhsp_pkg::HDR_LAST) begin
                // header still open
                if (r_in_last) begin
                    n_emit          = 1'b1;
                    n_res.kind      = rhsp_pkg::KIND_ERROR;
                    n_res.data_word = rhsp_pkg::ERR_SHORT;
                    n_res.out_last  = 1'b1;
                    n_byte_position = '0;
                    n_word_assembly = '0;
                    n_csrc_left     = '0;
                    n_discarding    = 1'b0;
                end
            end else if (r_in_last && r_header_flags[11:8] != 4'd0) begin
                // header ends the packet but csrc words were announced
                n_emit          = 1'b1;
                n_res.kind      = rhsp_pkg::KIND_ERROR;
                n_res.data_word = rhsp_pkg::ERR_SHORT;
                n_res.out_last  = 1'b1;
                n_byte_position = '0;
                n_word_assembly = '0;
                n_csrc_left     = '0;
                n_discarding    = 1'b0;
            end else begin
                // header complete
                n_emit              = 1'b1;
                n_res.kind          = rhsp_pkg::KIND_HEADER;
                n_res.version       = r_header_flags[15:14];
                n_res.padding_flag  = r_header_flags[13];
                n_res.ext_flag      = r_header_flags[12];
                n_res.src_count     = r_header_flags[11:8];
                n_res.marker        = r_header_flags[7];
                n_res.pt_code       = r_header_flags[6:0];
                n_res.seq_num       = r_seq_shadow;
                n_res.timestamp     = r_time_shadow;
                n_res.ssrc          = {r_ssrc_shadow[23:0], r_in_byte};
                n_csrc_left         = r_header_flags[11:8];
                n_word_assembly     = '0;
                if (r_in_last) begin
                    n_byte_position = '0;
                    n_csrc_left     = '0;
                    n_discarding    = 1'b0;
                end
            end
        end else if (r_csrc_left != 4'd0) begin
            // csrc list, one word per four octets
            n_word_assembly = s_word;
            n_byte_position = s_pos_inc;
            if (s_pos_inc[1:0] == 2'd0) begin
                n_csrc_left     = s_left_dec;
                n_word_assembly = '0;
                n_emit          = 1'b1;
                if (r_in_last && s_left_dec != 4'd0) begin
                    n_res.kind      = rhsp_pkg::KIND_ERROR;
                    n_res.data_word = rhsp_pkg::ERR_SHORT;
                    n_res.out_last  = 1'b1;
                end else begin
                    n_res.kind      = rhsp_pkg::KIND_CSRC;
                    n_res.data_word = s_word;
                end
            end else if (r_in_last) begin
                n_emit          = 1'b1;
                n_res.kind      = rhsp_pkg::KIND_ERROR;
                n_res.data_word = rhsp_pkg::ERR_SHORT;
                n_res.out_last  = 1'b1;
            end
            if (r_in_last) begin
                n_byte_position = '0;
                n_word_assembly = '0;
                n_csrc_left     = '0;
                n_discarding    = 1'b0;
            end
        end else begin
            // payload octet
            n_emit          = 1'b1;
            n_res.kind      = rhsp_pkg::KIND_PAYLOAD;
            n_res.data_word = {24'd0, r_in_byte};
            if (r_in_last) begin
                n_byte_position = '0;
                n_word_assembly = '0;
                n_csrc_left     = '0;
                n_discarding    = 1'b0;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (s_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.byte_value;
            r_in_last <= i_byte.in_last;
        end
    end

    // parser state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= '0;
            r_header_flags  <= '0;
            r_seq_shadow    <= '0;
            r_time_shadow   <= '0;
            r_ssrc_shadow   <= '0;
            r_word_assembly <= '0;
            r_csrc_left     <= '0;
            r_discarding    <= 1'b0;
        end else if (s_adv) begin
            r_byte_position <= n_byte_position;
            r_header_flags  <= n_header_flags;
            r_seq_shadow    <= n_seq_shadow;
            r_time_shadow   <= n_time_shadow;
            r_ssrc_shadow   <= n_ssrc_shadow;
            r_word_assembly <= n_word_assembly;
            r_csrc_left     <= n_csrc_left;
            r_discarding    <= n_discarding;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= s_adv && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv && n_emit) begin
            r_out <= n_res;
        end
    end

    // output drive
    assign o_result.valid         = r_out_valid;
    assign o_result.kind          = r_out.kind;
    assign o_result.version       = r_out.version;
    assign o_result.padding_flag  = r_out.padding_flag;
    assign o_result.ext_flag      = r_out.ext_flag;
    assign o_result.src_count     = r_out.src_count;
    assign o_result.marker        = r_out.marker;
    assign o_result.pt_code       = r_out.pt_code;
    assign o_result.seq_num       = r_out.seq_num;
    assign o_result.timestamp     = r_out.timestamp;
    assign o_result.ssrc          = r_out.ssrc;
    assign o_result.data_word     = r_out.data_word;
    assign o_result.out_last      = r_out.out_last;

    // csrc words are only pending once the fixed header is done
    a_csrc_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_csrc_left != 4'd0 |-> r_byte_position >= rhsp_pkg::HDR_LEN)
        else $error("csrc count pending inside fixed header");

    // discard mode always starts from a cleared position
    a_discard_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discarding |-> (r_byte_position == 7'd0 && r_csrc_left == 4'd0))
        else $error("discard mode with live position");

    // position never runs past the longest csrc list
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_position <= rhsp_pkg::MAX_POS)
        else $error("byte position out of range");

    // an error result always closes the packet
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == rhsp_pkg::KIND_ERROR) |-> r_out.out_last)
        else $error("error result without packet end");

endmodule

`default_nettype wire
